@@ rtl/irtx_pkg.sv @@
// Shared types and constants for the single-output infrared frame transmitter.
// Used by irtx_front, irtx_back and the top level; depends on nothing else.
package irtx_pkg;

	localparam int DefChannels    = 4;
	localparam int DefFrameBits   = 16;
	localparam int DefRepeatLimit = 4;

	localparam int FrameW = 16;
	localparam int RepW   = 3;

	localparam logic [3:0] NibEscape = 4'h4;
	localparam logic [3:0] NibCheck  = 4'hF;

	// Opcode of an input word.
	localparam logic OpTick    = 1'b0;
	localparam logic OpCommand = 1'b1;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		CFG_CARRIER_HALF = 3'd0,
		CFG_MARK_CYCLES  = 3'd1,
		CFG_SPACE_ZERO   = 3'd2,
		CFG_SPACE_ONE    = 3'd3,
		CFG_SPACE_SS     = 3'd4
	} cfg_idx_t;

	localparam logic [7:0]  RstCarrierHalf = 8'd13;
	localparam logic [5:0]  RstMarkCycles  = 6'd7;
	localparam logic [11:0] RstSpaceZero   = 12'd260;
	localparam logic [11:0] RstSpaceOne    = 12'd546;
	localparam logic [11:0] RstSpaceSs     = 12'd1014;

	typedef struct packed {
		logic [7:0]  carrier_half;
		logic [5:0]  mark_cycles;
		logic [11:0] space_zero;
		logic [11:0] space_one;
		logic [11:0] space_ss;
	} cfg_t;

	// One classified input word as it travels through the queue.
	typedef struct packed {
		logic       is_cmd;
		logic [1:0] channel;
		logic       mode_bit;
		logic       output_select;
		logic [3:0] power;
	} item_t;

endpackage

@@ rtl/irtx_front.sv @@
// Front end: accepts input words, classifies them and holds them in a
// two-entry queue for the back end. Depends on irtx_pkg.
module irtx_front
	import irtx_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       opcode,
	input  logic [1:0] channel,
	input  logic       mode_bit,
	input  logic       output_select,
	input  logic [3:0] power,
	output logic       q_valid,
	input  logic       q_pop,
	output item_t      q_item
);

	item_t      mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;
	item_t      item_in;

	assign in_stall = (count_q == 2'd2);
	assign push     = in_valid && !in_stall;
	assign q_valid  = (count_q != 2'd0);
	assign pop      = q_pop && q_valid;
	assign q_item   = mem_q[rd_ptr_q];

	always_comb begin
		item_in.is_cmd        = (opcode == OpCommand);
		item_in.channel       = channel;
		item_in.mode_bit      = mode_bit;
		item_in.output_select = output_select;
		item_in.power         = power;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 2'd2) else $error("queue count out of range");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == 2'd0 |=> !pop || $past(push)) else $error("pop from empty queue");
	a_ptr_match: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == 2'd0 || count_q == 2'd2) |-> wr_ptr_q == rd_ptr_q)
		else $error("queue pointers disagree with count");

endmodule

@@ rtl/irtx_back.sv @@
// Back end: executes one queued word a cycle unless its held result is stalled,
// against frame and timing state, into an output register. Depends on irtx_pkg.
module irtx_back
	import irtx_pkg::*;
#(
	parameter int CHANNELS     = DefChannels,
	parameter int FRAME_BITS   = DefFrameBits,
	parameter int REPEAT_LIMIT = DefRepeatLimit
) (
	input  logic            clk,
	input  logic            arst_n,
	input  cfg_t            cfg,
	input  logic            q_valid,
	output logic            q_pop,
	input  item_t           q_item,
	output logic            out_valid,
	input  logic            out_stall,
	output logic            ir_level,
	output logic            busy_res,
	output logic [RepW-1:0] repeat_count,
	output logic            rejected
);

	localparam int SymW = $clog2(FRAME_BITS + 2);
	localparam int PosW = $clog2(FRAME_BITS);

	logic [CHANNELS-1:0]   toggle_q, toggle_d;
	logic [FrameW-1:0]     last_frame_q, last_frame_d;
	logic [RepW-1:0]       repeats_q, repeats_d;
	logic [FRAME_BITS-1:0] shift_q, shift_d;
	logic [SymW-1:0]       sym_q, sym_d;
	logic                  in_space_q, in_space_d;
	logic [5:0]            carrier_q, carrier_d;
	logic [7:0]            half_q, half_d;
	logic [11:0]           space_q, space_d;
	logic                  sending_q, sending_d;
	logic                  pin_q, pin_d;
	logic                  rej_d;

	logic                  out_valid_q;
	logic                  rej_q;

	logic                  fire;
	logic [CHANNELS-1:0]   ch_hot;
	logic                  tog;
	logic [3:0]            n1, n2, n3, n4;
	logic [FrameW-1:0]     frame;
	logic [31:0]           frame32;
	logic [SymW-1:0]       pos_full;
	logic [11:0]           space_len;
	logic [7:0]            half_inc;
	logic [5:0]            carrier_inc;
	logic [11:0]           space_inc;

	assign q_pop = q_valid && (!out_valid_q || !out_stall);
	assign fire  = q_pop;

	// Frame assembly for a command.
	always_comb begin
		for (int i = 0; i < CHANNELS; i++) begin
			ch_hot[i] = (32'(q_item.channel) == i);
		end
		tog     = |(toggle_q & ch_hot);
		n1      = {tog, 1'b0, q_item.channel};
		n2      = NibEscape | {2'b00, q_item.mode_bit, q_item.output_select};
		n3      = q_item.power;
		n4      = NibCheck ^ n1 ^ n2 ^ n3;
		frame   = {n1, n2, n3, n4};
		frame32 = 32'(frame);
	end

	// Space length of the current symbol: start and stop use their own.
	always_comb begin
		pos_full = SymW'(FRAME_BITS) - sym_q;
		if (sym_q == '0 || sym_q > SymW'(FRAME_BITS)) begin
			space_len = cfg.space_ss;
		end else if (shift_q[pos_full[PosW-1:0]]) begin
			space_len = cfg.space_one;
		end else begin
			space_len = cfg.space_zero;
		end
	end

	assign half_inc    = half_q + 8'd1;
	assign carrier_inc = carrier_q + 6'd1;
	assign space_inc   = space_q + 12'd1;

	always_comb begin
		toggle_d     = toggle_q;
		last_frame_d = last_frame_q;
		repeats_d    = repeats_q;
		shift_d      = shift_q;
		sym_d        = sym_q;
		in_space_d   = in_space_q;
		carrier_d    = carrier_q;
		half_d       = half_q;
		space_d      = space_q;
		sending_d    = sending_q;
		pin_d        = pin_q;
		rej_d        = 1'b0;
		if (q_item.is_cmd) begin
			if (sending_q) begin
				rej_d = 1'b1;
			end else begin
				if (frame == last_frame_q) begin
					if (repeats_q < RepW'(REPEAT_LIMIT)) begin
						repeats_d = repeats_q + RepW'(1);
					end
				end else begin
					last_frame_d = frame;
					repeats_d    = '0;
				end
				toggle_d   = toggle_q ^ ch_hot;
				shift_d    = frame32[FRAME_BITS-1:0];
				sym_d      = '0;
				in_space_d = 1'b0;
				carrier_d  = '0;
				half_d     = '0;
				space_d    = '0;
				sending_d  = 1'b1;
				pin_d      = 1'b1;
			end
		end else if (!sending_q) begin
			pin_d = 1'b0;
		end else if (!in_space_q) begin
			half_d = half_inc;
			if (half_inc >= cfg.carrier_half || half_inc == 8'd0) begin
				half_d = '0;
				if (pin_q) begin
					pin_d = 1'b0;
				end else begin
					carrier_d = carrier_inc;
					if (carrier_inc >= cfg.mark_cycles || carrier_inc == 6'd0) begin
						carrier_d  = '0;
						in_space_d = 1'b1;
						space_d    = '0;
					end else begin
						pin_d = 1'b1;
					end
				end
			end
		end else begin
			space_d = space_inc;
			if (space_inc >= space_len || space_inc == 12'd0) begin
				space_d = '0;
				if (sym_q >= SymW'(FRAME_BITS + 1)) begin
					sending_d  = 1'b0;
					in_space_d = 1'b0;
					sym_d      = '0;
					pin_d      = 1'b0;
				end else begin
					sym_d      = sym_q + SymW'(1);
					in_space_d = 1'b0;
					half_d     = '0;
					carrier_d  = '0;
					pin_d      = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			toggle_q     <= '0;
			last_frame_q <= '0;
			repeats_q    <= '0;
			shift_q      <= '0;
			sym_q        <= '0;
			in_space_q   <= 1'b0;
			carrier_q    <= '0;
			half_q       <= '0;
			space_q      <= '0;
			sending_q    <= 1'b0;
			pin_q        <= 1'b0;
			out_valid_q  <= 1'b0;
			rej_q        <= 1'b0;
		end else begin
			if (fire) begin
				toggle_q     <= toggle_d;
				last_frame_q <= last_frame_d;
				repeats_q    <= repeats_d;
				shift_q      <= shift_d;
				sym_q        <= sym_d;
				in_space_q   <= in_space_d;
				carrier_q    <= carrier_d;
				half_q       <= half_d;
				space_q      <= space_d;
				sending_q    <= sending_d;
				pin_q        <= pin_d;
				rej_q        <= rej_d;
				out_valid_q  <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// The result word mirrors the state left by the last executed word.
	assign out_valid    = out_valid_q;
	assign ir_level     = pin_q;
	assign busy_res     = sending_q;
	assign repeat_count = repeats_q;
	assign rejected     = rej_q;

	a_rej_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rej_q |-> sending_q) else $error("rejected while not busy");
	a_idle_dark: assert property (@(posedge clk) disable iff (!arst_n)
		!sending_q |-> !pin_q && !in_space_q) else $error("pin driven while idle");
	a_rep_limit: assert property (@(posedge clk) disable iff (!arst_n)
		repeats_q <= RepW'(REPEAT_LIMIT)) else $error("repeat count past limit");
	a_sym_range: assert property (@(posedge clk) disable iff (!arst_n)
		sym_q <= SymW'(FRAME_BITS + 1)) else $error("symbol index past stop");

endmodule

@@ rtl/ir_single_output_frame_transmitter_core.sv @@
// An accepted input word passes through the two-entry queue, the back-end step
// and the output register. One input word per cycle is taken unless the queue is
// full or the output stalls; the queue and output register decouple the channels.
// Reset (arst_n, asynchronous): toggle bits, frame history and all timing
// counters clear, the LED pin is low and timing registers take their defaults.
module ir_single_output_frame_transmitter_core
	import irtx_pkg::*;
#(
	parameter int CHANNELS     = DefChannels,
	parameter int FRAME_BITS   = DefFrameBits,
	parameter int REPEAT_LIMIT = DefRepeatLimit
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  logic            opcode,
	input  logic [1:0]      channel,
	input  logic            mode_bit,
	input  logic            output_select,
	input  logic [3:0]      power,
	output logic            out_valid,
	input  logic            out_stall,
	output logic            ir_level,
	output logic            busy_res,
	output logic [RepW-1:0] repeat_count,
	output logic            rejected,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic [2:0]      cfg_index,
	input  logic [11:0]     cfg_data
);

	cfg_t  cfg_q;
	logic  q_valid;
	logic  q_pop;
	item_t q_item;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.carrier_half <= RstCarrierHalf;
			cfg_q.mark_cycles  <= RstMarkCycles;
			cfg_q.space_zero   <= RstSpaceZero;
			cfg_q.space_one    <= RstSpaceOne;
			cfg_q.space_ss     <= RstSpaceSs;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_CARRIER_HALF: cfg_q.carrier_half <= cfg_data[7:0];
				CFG_MARK_CYCLES:  cfg_q.mark_cycles  <= cfg_data[5:0];
				CFG_SPACE_ZERO:   cfg_q.space_zero   <= cfg_data;
				CFG_SPACE_ONE:    cfg_q.space_one    <= cfg_data;
				CFG_SPACE_SS:     cfg_q.space_ss     <= cfg_data;
				default:          cfg_q              <= cfg_q;
			endcase
		end
	end

	irtx_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.opcode        (opcode),
		.channel       (channel),
		.mode_bit      (mode_bit),
		.output_select (output_select),
		.power         (power),
		.q_valid       (q_valid),
		.q_pop         (q_pop),
		.q_item        (q_item)
	);

	irtx_back #(
		.CHANNELS     (CHANNELS),
		.FRAME_BITS   (FRAME_BITS),
		.REPEAT_LIMIT (REPEAT_LIMIT)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.q_valid      (q_valid),
		.q_pop        (q_pop),
		.q_item       (q_item),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.ir_level     (ir_level),
		.busy_res     (busy_res),
		.repeat_count (repeat_count),
		.rejected     (rejected)
	);

endmodule

@@ bench/irtx_frame_checker.sv @@
// Checker for the infrared frame transmitter: watches the input, output and register
// channels, predicts each result word and compares it. Depends on irtx_pkg only.
module irtx_frame_checker
	import irtx_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            in_stall,
	input  logic            opcode,
	input  logic [1:0]      channel,
	input  logic            mode_bit,
	input  logic            output_select,
	input  logic [3:0]      power,
	input  logic            out_valid,
	input  logic            out_stall,
	input  logic            ir_level,
	input  logic            busy_res,
	input  logic [RepW-1:0] repeat_count,
	input  logic            rejected,
	input  logic            cfg_valid,
	input  logic            cfg_ready,
	input  logic [2:0]      cfg_index,
	input  logic [11:0]     cfg_data,
	output int              fail_count,
	output int              pending,
	output bit              tx_active
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ShownMismatches = 10;

	typedef struct packed {
		logic            led;
		logic            busy;
		logic [RepW-1:0] reps;
		logic            dropped;
	} tx_status_t;

	tx_status_t status_due[$];
	int mismatches;

	cfg_t timing;
	bit [DefChannels-1:0] toggle;
	bit [FrameW-1:0] prev_frame;
	bit [FrameW-1:0] frame_bits;
	bit [RepW-1:0] reps;
	bit [4:0] symbol;
	bit spacing;
	bit led;
	bit active;
	bit [5:0] periods;
	bit [7:0] half;
	bit [11:0] gap;

	// Start and stop symbols use their own space; data symbols go MSB first.
	function automatic bit [11:0] gap_for_symbol();
		if (symbol == 0 || symbol > DefFrameBits)
			return timing.space_ss;
		return frame_bits[DefFrameBits - symbol] ? timing.space_one : timing.space_zero;
	endfunction

	function automatic void advance_time();
		if (!active) begin
			led = 1'b0;
			return;
		end
		if (!spacing) begin
			half = half + 8'd1;
			if (half >= timing.carrier_half || half == 0) begin
				half = '0;
				if (led) begin
					led = 1'b0;
				end else begin
					periods = periods + 6'd1;
					// The burst ends only after its last low half.
					if (periods >= timing.mark_cycles || periods == 0) begin
						periods = '0;
						spacing = 1'b1;
						gap = '0;
					end else begin
						led = 1'b1;
					end
				end
			end
		end else begin
			gap = gap + 12'd1;
			if (gap >= gap_for_symbol() || gap == 0) begin
				gap = '0;
				if (symbol >= DefFrameBits + 1) begin
					active = 1'b0;
					spacing = 1'b0;
					symbol = '0;
					led = 1'b0;
				end else begin
					symbol++;
					spacing = 1'b0;
					half = '0;
					periods = '0;
					led = 1'b1;
				end
			end
		end
	endfunction

	function automatic void start_frame(item_t w);
		bit tog;
		bit [3:0] n1, n2, n3, n4;
		bit [FrameW-1:0] frame;
		tog = (w.channel < DefChannels) ? toggle[w.channel] : 1'b0;
		n1 = {tog, 1'b0, w.channel};
		n2 = NibEscape | {2'b00, w.mode_bit, w.output_select};
		n3 = w.power;
		n4 = NibCheck ^ n1 ^ n2 ^ n3;
		frame = {n1, n2, n3, n4};
		if (frame == prev_frame) begin
			if (reps < DefRepeatLimit)
				reps++;
		end else begin
			prev_frame = frame;
			reps = '0;
		end
		if (w.channel < DefChannels)
			toggle[w.channel] = ~tog;
		frame_bits = frame;
		symbol = '0;
		spacing = 1'b0;
		periods = '0;
		half = '0;
		gap = '0;
		active = 1'b1;
		led = 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		tx_status_t want, got;
		item_t w;
		if (!arst_n) begin
			timing = '{RstCarrierHalf, RstMarkCycles, RstSpaceZero, RstSpaceOne, RstSpaceSs};
			toggle = '0;
			prev_frame = '0;
			frame_bits = '0;
			reps = '0;
			symbol = '0;
			spacing = 1'b0;
			led = 1'b0;
			active = 1'b0;
			periods = '0;
			half = '0;
			gap = '0;
			status_due.delete();
			mismatches = 0;
			fail_count <= 0;
			pending <= 0;
			tx_active <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_CARRIER_HALF: timing.carrier_half = cfg_data[7:0];
					CFG_MARK_CYCLES:  timing.mark_cycles = cfg_data[5:0];
					CFG_SPACE_ZERO:   timing.space_zero = cfg_data;
					CFG_SPACE_ONE:    timing.space_one = cfg_data;
					CFG_SPACE_SS:     timing.space_ss = cfg_data;
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				got = {ir_level, busy_res, repeat_count, rejected};
				if (status_due.size() == 0) begin
					mismatches++;
					if (mismatches <= ShownMismatches)
						$display("%0t: unexpected result word: ir_level %b busy %b repeat %0d rejected %b",
							$realtime, got.led, got.busy, got.reps, got.dropped);
				end else begin
					want = status_due.pop_front();
					if (want !== got) begin
						mismatches++;
						if (mismatches <= ShownMismatches)
							$display({"%0t: result mismatch (expected/actual): ir_level %b/%b ",
								"busy %b/%b repeat %0d/%0d rejected %b/%b"}, $realtime,
								want.led, got.led, want.busy, got.busy,
								want.reps, got.reps, want.dropped, got.dropped);
					end
				end
			end
			if (in_valid && !in_stall) begin
				w = {opcode, channel, mode_bit, output_select, power};
				want.dropped = 1'b0;
				if (w.is_cmd == OpCommand) begin
					if (active)
						want.dropped = 1'b1;
					else
						start_frame(w);
				end else begin
					advance_time();
				end
				want.led = led;
				want.busy = active;
				want.reps = reps;
				status_due.push_back(want);
			end
			pending <= status_due.size();
			tx_active <= active;
			fail_count <= mismatches;
		end
	end

endmodule

@@ bench/ir_single_output_frame_transmitter_core_test.sv @@
// Top of the transmitter regression: clock, reset, stimulus and verdict.
// Depends on irtx_pkg, the transmitter core and irtx_frame_checker.
module ir_single_output_frame_transmitter_core_test import irtx_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ItemBudget   = 400;
	localparam int CalmTail     = 60;
	localparam int StallLimit   = 2000;
	localparam logic [2:0] CfgNoSuch = 3'd7;

	logic            clk = 1'b0;
	logic            arst_n = 1'b0;
	logic            in_valid = 1'b0;
	logic            in_stall;
	logic            opcode = OpTick;
	logic [1:0]      channel = '0;
	logic            mode_bit = 1'b0;
	logic            output_select = 1'b0;
	logic [3:0]      power = '0;
	logic            out_valid;
	logic            out_stall = 1'b0;
	logic            ir_level;
	logic            busy_res;
	logic [RepW-1:0] repeat_count;
	logic            rejected;
	logic            cfg_valid = 1'b0;
	logic            cfg_ready;
	logic [2:0]      cfg_index = '0;
	logic [11:0]     cfg_data = '0;

	int fail_count;
	int pending;
	bit tx_active;
	bit calm = 1'b0;
	int stall_left = 0;
	int items_sent = 0;

	ir_single_output_frame_transmitter_core u_dut (.*);
	irtx_frame_checker u_checker (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (stall_left != 0)
			stall_left--;
		else if (!calm && $urandom_range(0, 15) == 0)
			stall_left = $urandom_range(1, 14);
		out_stall <= (stall_left != 0);
	end

	function automatic item_t random_command();
		item_t w;
		w.is_cmd = OpCommand;
		w.channel = $urandom_range(0, 3);
		w.mode_bit = $urandom_range(0, 1);
		w.output_select = $urandom_range(0, 1);
		w.power = $urandom_range(0, 15);
		return w;
	endfunction

	// Tick words carry random payload bits that the block must ignore.
	function automatic item_t tick_word();
		item_t w;
		w = random_command();
		w.is_cmd = OpTick;
		return w;
	endfunction

	task automatic send_word(item_t w);
		if (items_sent >= ItemBudget - CalmTail)
			calm = 1'b1;
		if (!calm && $urandom_range(0, 15) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		in_valid <= 1'b1;
		{opcode, channel, mode_bit, output_select, power} <= w;
		do @(posedge clk); while (in_stall);
		items_sent++;
	endtask

	task automatic flush_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// tx_active lags by one word, so the loop stops only after a tick that
	// found the transmitter idle; a late command then still gets its frame sent.
	// The loop also stops once the word budget of the run is spent.
	task automatic run_ticks(int reject_odds);
		bit was_cmd;
		do begin
			was_cmd = reject_odds != 0 && $urandom_range(1, reject_odds) == 1;
			if (was_cmd)
				send_word(random_command());
			else
				send_word(tick_word());
			if (!calm && $urandom_range(0, 399) == 0)
				flush_results();
		end while ((tx_active || was_cmd) && items_sent < ItemBudget);
	endtask

	task automatic run_frame(item_t cmd, int reject_odds);
		send_word(cmd);
		run_ticks(reject_odds);
	endtask

	task automatic program_timing(cfg_t t, bit poke_unused);
		logic [2:0] idx [6];
		logic [11:0] val [6];
		idx = '{CFG_CARRIER_HALF, CFG_MARK_CYCLES, CFG_SPACE_ZERO, CFG_SPACE_ONE,
			CFG_SPACE_SS, CfgNoSuch};
		// Narrow registers ignore the upper data bits, so those carry noise.
		val = '{{4'($urandom), t.carrier_half}, {6'($urandom), t.mark_cycles},
			t.space_zero, t.space_one, t.space_ss, 12'($urandom)};
		flush_results();
		for (int i = 0; i < (poke_unused ? 6 : 5); i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= val[i];
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
	endtask

	initial begin : watchdog
		int quiet_cycles;
		quiet_cycles = 0;
		@(posedge arst_n);
		while (quiet_cycles < StallLimit) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("ir_single_output_frame_transmitter_core regression: fail");
		$finish;
	end

	initial begin : stimulus
		cfg_t timing;
		int phase;
		bit stretch_calm;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: idle ticks, then the start of a frame at reset timing with a
		// command dropped mid-frame. Fast timing then finishes the frame.
		repeat (3) send_word(tick_word());
		send_word(item_t'{OpCommand, 2'd0, 1'b0, 1'b0, 4'd0});
		repeat (20) send_word(tick_word());
		send_word(item_t'{OpCommand, 2'd3, 1'b1, 1'b1, 4'd15});
		repeat (5) send_word(tick_word());
		program_timing('{8'd1, 6'd1, 12'd1, 12'd2, 12'd3}, 1'b1);
		run_ticks(0);

		// All timing registers zero, each count acting as one.
		// Same channel twice in a row: the toggle bit flips each time.
		program_timing('{8'd0, 6'd0, 12'd0, 12'd0, 12'd0}, 1'b0);
		run_frame(item_t'{OpCommand, 2'd0, 1'b1, 1'b1, 4'd15}, 0);
		run_frame(item_t'{OpCommand, 2'd0, 1'b1, 1'b1, 4'd15}, 0);

		phase = 0;
		while (items_sent < ItemBudget) begin
			timing.carrier_half = $urandom_range(0, 2);
			timing.mark_cycles = $urandom_range(0, 2);
			timing.space_zero = $urandom_range(0, 4);
			timing.space_one = $urandom_range(0, 4);
			timing.space_ss = $urandom_range(0, 4);
			program_timing(timing, phase % 2 == 0);
			stretch_calm = $urandom_range(0, 4) == 0;
			calm = stretch_calm || items_sent >= ItemBudget - CalmTail;
			run_frame(random_command(), 12);
			if (items_sent < ItemBudget && $urandom_range(0, 3) == 0)
				repeat ($urandom_range(1, 4)) send_word(tick_word());
			phase++;
		end

		calm = 1'b1;
		flush_results();
		repeat (8) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("ir_single_output_frame_transmitter_core regression: pass");
		else
			$display("ir_single_output_frame_transmitter_core regression: fail");
		$finish;
	end

endmodule
